>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the static point filter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define SPF_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// invariant checked at every rising clock edge outside reset
`define SPF_ASSERT_ALWAYS(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant check failed");

`endif

>>> src/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg
// Widths, constants and types shared by the static point filter.
// ----------------------------------------------------------------------------
package spf_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int SNR_WIDTH   = 16;
  localparam int SCALE_BITS  = 30;
  localparam int DIR_FRAC    = 30;
  localparam int SHIFT_MAX   = (COORD_WIDTH > SCALE_BITS) ? COORD_WIDTH - SCALE_BITS : 0;
  localparam int SUM_W       = 2 * SCALE_BITS + 2;
  localparam int ROOT_W      = SCALE_BITS + 1;
  localparam int DREM_W      = ROOT_W + 1;
  localparam int QUO_W       = DIR_FRAC + 1;
  localparam int DIR_W       = QUO_W + 1;
  localparam int PROD_W      = COORD_WIDTH + DIR_W;
  localparam int DOT_W       = PROD_W + 2;
  localparam int EXP_W       = DOT_W - DIR_FRAC;
  localparam int RES_W       = EXP_W + 1;
  localparam int THR_W       = COORD_WIDTH - 1;
  localparam int CFG_IDX_W   = 2;
  localparam int FIFO_DEPTH  = 2;

  localparam logic [63:0] SMALL_LIMIT =
    ((64'd1 << (2 * FRAC_BITS)) + 64'd99999999) / 64'd100000000;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(32768);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EGO_X,
    CFG_EGO_Y,
    CFG_EGO_Z,
    CFG_THRESHOLD
  } cfg_reg_t;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [SNR_WIDTH-1:0]   snr_t;
  typedef logic [SCALE_BITS-1:0]         scaled_t;

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    snr_t   snr;
    coord_t speed;
    logic   last;
  } item_t;

  typedef struct packed {
    item_t                 item;
    scaled_t [2:0]         mag;
    logic    [2:0]         neg;
    logic    [SUM_W-1:0]   sum;
    logic                  near_zero;
  } cls_t;

  typedef struct packed {
    coord_t             vel_x;
    coord_t             vel_y;
    coord_t             vel_z;
    logic [THR_W-1:0]   thr;
  } ego_t;

endpackage

>>> src/spf_ifs.sv
// ----------------------------------------------------------------------------
// spf channel interfaces
// Detection input, filtered point output and register write channels.
// ----------------------------------------------------------------------------
interface spf_det_if;
  logic            valid;
  logic            ready;
  spf_pkg::coord_t pos_x;
  spf_pkg::coord_t pos_y;
  spf_pkg::coord_t pos_z;
  spf_pkg::snr_t   snr_level;
  spf_pkg::coord_t radial_speed;
  logic            frame_last;

  modport source(output valid, pos_x, pos_y, pos_z, snr_level, radial_speed, frame_last,
                 input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, snr_level, radial_speed, frame_last,
               output ready);
endinterface

interface spf_pnt_if;
  logic            valid;
  logic            ready;
  logic            keep;
  spf_pkg::coord_t out_x;
  spf_pkg::coord_t out_y;
  spf_pkg::coord_t out_z;
  spf_pkg::snr_t   out_snr;
  spf_pkg::coord_t out_speed;
  logic            out_last;

  modport source(output valid, keep, out_x, out_y, out_z, out_snr, out_speed, out_last,
                 input ready);
  modport sink(input valid, keep, out_x, out_y, out_z, out_snr, out_speed, out_last,
               output ready);
endinterface

interface spf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [spf_pkg::CFG_IDX_W-1:0]     index;
  logic [spf_pkg::COORD_WIDTH-1:0]   data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> src/spf_front.sv
// ----------------------------------------------------------------------------
// spf_front
// Accept detections, scale positions and form the sum of squares.
// ----------------------------------------------------------------------------
module spf_front (
  input  logic          clk,
  input  logic          rst,
  spf_det_if.sink       det,
  output spf_pkg::cls_t cls,
  output logic          cls_valid,
  input  logic          cls_ready
);

  logic                          adv;
  logic                          a_valid;
  spf_pkg::item_t                a_item;
  spf_pkg::scaled_t [2:0]        a_mag;
  logic [2:0]                    a_neg;
  logic                          a_noshift;
  logic                          b_valid;
  spf_pkg::cls_t                 b_cls;
  logic [spf_pkg::COORD_WIDTH-1:0] mag_x, mag_y, mag_z, mx;
  logic [7:0]                    sh;
  logic [spf_pkg::SUM_W-1:0]     sum;

  assign adv       = !b_valid || cls_ready;
  assign det.ready = adv;
  assign cls       = b_cls;
  assign cls_valid = b_valid;

  always_comb begin
    mag_x = det.pos_x[spf_pkg::COORD_WIDTH-1] ? spf_pkg::COORD_WIDTH'(-det.pos_x)
                                               : spf_pkg::COORD_WIDTH'(det.pos_x);
    mag_y = det.pos_y[spf_pkg::COORD_WIDTH-1] ? spf_pkg::COORD_WIDTH'(-det.pos_y)
                                               : spf_pkg::COORD_WIDTH'(det.pos_y);
    mag_z = det.pos_z[spf_pkg::COORD_WIDTH-1] ? spf_pkg::COORD_WIDTH'(-det.pos_z)
                                               : spf_pkg::COORD_WIDTH'(det.pos_z);
    mx = mag_x;
    if (mag_y > mx) begin
      mx = mag_y;
    end
    if (mag_z > mx) begin
      mx = mag_z;
    end
    sh = '0;
    for (int i = 0; i < spf_pkg::SHIFT_MAX; i++) begin
      if ((64'(mx) >> sh) >= (64'd1 << spf_pkg::SCALE_BITS)) begin
        sh = sh + 8'd1;
      end
    end
  end

  assign sum = spf_pkg::SUM_W'(a_mag[0]) * spf_pkg::SUM_W'(a_mag[0])
             + spf_pkg::SUM_W'(a_mag[1]) * spf_pkg::SUM_W'(a_mag[1])
             + spf_pkg::SUM_W'(a_mag[2]) * spf_pkg::SUM_W'(a_mag[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= det.valid;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_item.pos_x <= det.pos_x;
      a_item.pos_y <= det.pos_y;
      a_item.pos_z <= det.pos_z;
      a_item.snr   <= det.snr_level;
      a_item.speed <= det.radial_speed;
      a_item.last  <= det.frame_last;
      a_mag[0]     <= spf_pkg::SCALE_BITS'(64'(mag_x) >> sh);
      a_mag[1]     <= spf_pkg::SCALE_BITS'(64'(mag_y) >> sh);
      a_mag[2]     <= spf_pkg::SCALE_BITS'(64'(mag_z) >> sh);
      a_neg        <= {det.pos_z[spf_pkg::COORD_WIDTH-1], det.pos_y[spf_pkg::COORD_WIDTH-1],
                       det.pos_x[spf_pkg::COORD_WIDTH-1]};
      a_noshift    <= (sh == 8'd0);
      b_cls.item   <= a_item;
      b_cls.mag    <= a_mag;
      b_cls.neg    <= a_neg;
      b_cls.sum    <= sum;
      b_cls.near_zero <= a_noshift && (sum < spf_pkg::SUM_W'(spf_pkg::SMALL_LIMIT));
    end
  end

endmodule

>>> src/spf_fifo.sv
// ----------------------------------------------------------------------------
// spf_fifo
// Short queue between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spf_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  spf_pkg::cls_t push_data,
  output logic          full,
  input  logic          pop,
  output spf_pkg::cls_t pop_data,
  output logic          empty
);

  localparam int PTR_W = (spf_pkg::FIFO_DEPTH > 1) ? $clog2(spf_pkg::FIFO_DEPTH) : 1;

  spf_pkg::cls_t    mem [spf_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [PTR_W:0]   count;

  assign full     = (count == (PTR_W + 1)'(spf_pkg::FIFO_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(spf_pkg::FIFO_DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(spf_pkg::FIFO_DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W + 1)'(1);
      end
    end
  end

  `SPF_ASSERT_IMP(a_push_room, clk, rst, push, !full)
  `SPF_ASSERT_IMP(a_pop_data, clk, rst, pop, !empty)
  `SPF_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= (PTR_W + 1)'(spf_pkg::FIFO_DEPTH))

endmodule

>>> src/spf_back.sv
// ----------------------------------------------------------------------------
// spf_back
// Root, direction division, ego dot product and static decision pipeline.
// ----------------------------------------------------------------------------
module spf_back (
  input  logic          clk,
  input  logic          rst,
  input  spf_pkg::cls_t cls,
  input  logic          cls_valid,
  output logic          cls_ready,
  input  spf_pkg::ego_t ego,
  spf_pnt_if.source     pnt
);

  localparam int RW = spf_pkg::ROOT_W;
  localparam int QW = spf_pkg::QUO_W;

  logic en;

  logic                       sq_v    [RW];
  spf_pkg::cls_t              sq_c    [RW];
  logic [spf_pkg::SUM_W-1:0]  sq_rem  [RW];
  logic [RW-1:0]              sq_root [RW];

  logic                       dv_v    [QW];
  spf_pkg::cls_t              dv_c    [QW];
  logic [RW-1:0]              dv_root [QW];
  logic [spf_pkg::DREM_W-1:0] dv_rem  [QW][3];
  logic [QW-1:0]              dv_q    [QW][3];

  logic                              pr_v;
  spf_pkg::cls_t                     pr_c;
  logic signed [spf_pkg::PROD_W-1:0] pr [3];
  logic signed [spf_pkg::DIR_W-1:0]  dir [3];
  logic signed [spf_pkg::PROD_W-1:0] vel [3];

  logic                              ex_v;
  spf_pkg::cls_t                     ex_c;
  logic signed [spf_pkg::EXP_W-1:0]  ex_e;
  logic signed [spf_pkg::DOT_W-1:0]  dot;

  logic signed [spf_pkg::RES_W-1:0]  resid;
  logic [spf_pkg::RES_W-1:0]         amag;

  logic             o_valid;
  logic             o_keep;
  spf_pkg::item_t   o_item;

  assign en        = !o_valid || pnt.ready;
  assign cls_ready = en;

  for (genvar g = 0; g < RW; g++) begin : g_root
    localparam int K = RW - 1 - g;
    logic                        p_v;
    spf_pkg::cls_t               p_c;
    logic [spf_pkg::SUM_W-1:0]   p_rem;
    logic [RW-1:0]               p_root;
    logic [spf_pkg::SUM_W+1:0]   trial;
    logic                        take;

    if (g == 0) begin : g_first
      assign p_v    = cls_valid;
      assign p_c    = cls;
      assign p_rem  = cls.sum;
      assign p_root = '0;
    end else begin : g_next
      assign p_v    = sq_v[g-1];
      assign p_c    = sq_c[g-1];
      assign p_rem  = sq_rem[g-1];
      assign p_root = sq_root[g-1];
    end

    assign trial = ((spf_pkg::SUM_W + 2)'(p_root) << (K + 1))
                 + ((spf_pkg::SUM_W + 2)'(1) << (2 * K));
    assign take  = (spf_pkg::SUM_W + 2)'(p_rem) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[g] <= 1'b0;
      end else if (en) begin
        sq_v[g] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_c[g]    <= p_c;
        sq_rem[g]  <= take ? spf_pkg::SUM_W'((spf_pkg::SUM_W + 2)'(p_rem) - trial) : p_rem;
        sq_root[g] <= take ? (p_root | (RW'(1) << K)) : p_root;
      end
    end
  end

  for (genvar h = 0; h < QW; h++) begin : g_div
    logic          p_v;
    spf_pkg::cls_t p_c;
    logic [RW-1:0] p_root;

    if (h == 0) begin : g_first
      assign p_v    = sq_v[RW-1];
      assign p_c    = sq_c[RW-1];
      assign p_root = sq_root[RW-1];
    end else begin : g_next
      assign p_v    = dv_v[h-1];
      assign p_c    = dv_c[h-1];
      assign p_root = dv_root[h-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[h] <= 1'b0;
      end else if (en) begin
        dv_v[h] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_c[h]    <= p_c;
        dv_root[h] <= p_root;
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [spf_pkg::DREM_W-1:0] p_rem;
      logic [QW-1:0]              p_q;
      logic                       nbit;
      logic [spf_pkg::DREM_W:0]   t;
      logic                       ge;

      if (h == 0) begin : g_first
        assign p_rem = spf_pkg::DREM_W'(p_c.mag[l] >> 1);
        assign p_q   = '0;
        assign nbit  = p_c.mag[l][0];
      end else begin : g_next
        assign p_rem = dv_rem[h-1][l];
        assign p_q   = dv_q[h-1][l];
        assign nbit  = 1'b0;
      end

      assign t  = {p_rem, nbit};
      assign ge = t >= (spf_pkg::DREM_W + 1)'(p_root);

      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem[h][l] <= ge ? spf_pkg::DREM_W'(t - (spf_pkg::DREM_W + 1)'(p_root))
                             : spf_pkg::DREM_W'(t);
          dv_q[h][l]   <= {p_q[QW-2:0], ge};
        end
      end
    end
  end

  assign vel[0] = spf_pkg::PROD_W'(ego.vel_x);
  assign vel[1] = spf_pkg::PROD_W'(ego.vel_y);
  assign vel[2] = spf_pkg::PROD_W'(ego.vel_z);

  for (genvar l = 0; l < 3; l++) begin : g_dir
    assign dir[l] = dv_c[QW-1].neg[l] ? -$signed({1'b0, dv_q[QW-1][l]})
                                      : $signed({1'b0, dv_q[QW-1][l]});
  end

  assign dot = spf_pkg::DOT_W'(pr[0]) + spf_pkg::DOT_W'(pr[1]) + spf_pkg::DOT_W'(pr[2]);

  assign resid = spf_pkg::RES_W'(ex_c.item.speed) + spf_pkg::RES_W'(ex_e);
  assign amag  = resid[spf_pkg::RES_W-1] ? spf_pkg::RES_W'(-resid) : spf_pkg::RES_W'(resid);

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_v    <= 1'b0;
      ex_v    <= 1'b0;
      o_valid <= 1'b0;
    end else if (en) begin
      pr_v    <= dv_v[QW-1];
      ex_v    <= pr_v;
      o_valid <= ex_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr_c   <= dv_c[QW-1];
      pr[0]  <= vel[0] * spf_pkg::PROD_W'(dir[0]);
      pr[1]  <= vel[1] * spf_pkg::PROD_W'(dir[1]);
      pr[2]  <= vel[2] * spf_pkg::PROD_W'(dir[2]);
      ex_c   <= pr_c;
      ex_e   <= pr_c.near_zero ? '0 : spf_pkg::EXP_W'(dot >>> spf_pkg::DIR_FRAC);
      o_item <= ex_c.item;
      o_keep <= amag < spf_pkg::RES_W'(ego.thr);
    end
  end

  assign pnt.valid     = o_valid;
  assign pnt.keep      = o_keep;
  assign pnt.out_x     = o_item.pos_x;
  assign pnt.out_y     = o_item.pos_y;
  assign pnt.out_z     = o_item.pos_z;
  assign pnt.out_snr   = o_item.snr;
  assign pnt.out_speed = o_item.speed;
  assign pnt.out_last  = o_item.last;

endmodule

>>> src/radar_static_point_filter_top.sv
// A detection passes the front registers, the queue, the root and divider stages, then the product registers.
// One detection per cycle while the output is not stalled; the root and divider are fully pipelined.
// A 2-entry queue splits the front and back, so each side stalls on its own.
// Reset clears all valid state; ego velocity resets to 0, threshold to 0.5 m/s.
// ----------------------------------------------------------------------------
// radar_static_point_filter_top
// Flag radar detections whose Doppler matches a static world under ego motion.
// ----------------------------------------------------------------------------
module radar_static_point_filter_top (
  input  logic      clk,
  input  logic      rst,
  spf_det_if.sink   det,
  spf_pnt_if.source pnt,
  spf_cfg_if.sink   cfg
);

  spf_pkg::ego_t ego;
  spf_pkg::cls_t f_cls;
  spf_pkg::cls_t q_cls;
  logic          f_valid;
  logic          f_ready;
  logic          q_full;
  logic          q_empty;
  logic          b_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ego.vel_x <= '0;
      ego.vel_y <= '0;
      ego.vel_z <= '0;
      ego.thr   <= spf_pkg::THR_RESET;
    end else if (cfg.valid) begin
      unique case (spf_pkg::cfg_reg_t'(cfg.index))
        spf_pkg::CFG_EGO_X:     ego.vel_x <= cfg.data;
        spf_pkg::CFG_EGO_Y:     ego.vel_y <= cfg.data;
        spf_pkg::CFG_EGO_Z:     ego.vel_z <= cfg.data;
        spf_pkg::CFG_THRESHOLD: ego.thr   <= cfg.data[spf_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign f_ready = !q_full;

  spf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .det       (det),
    .cls       (f_cls),
    .cls_valid (f_valid),
    .cls_ready (f_ready)
  );

  spf_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid && f_ready),
    .push_data (f_cls),
    .full      (q_full),
    .pop       (!q_empty && b_ready),
    .pop_data  (q_cls),
    .empty     (q_empty)
  );

  spf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cls       (q_cls),
    .cls_valid (!q_empty),
    .cls_ready (b_ready),
    .ego       (ego),
    .pnt       (pnt)
  );

endmodule
